// ===== hw/rtl/ptt_pkg.sv =====
// Shared types and constants of the PID controller with twiddle tuning.
package ptt_pkg;

  // Register indexes on the configuration port
  localparam logic [1:0] RegKp   = 2'd0;
  localparam logic [1:0] RegKi   = 2'd1;
  localparam logic [1:0] RegKd   = 2'd2;
  localparam logic [1:0] RegTune = 2'd3;

  // Horizon length that forces a tuning step
  localparam logic [10:0] HorizonMax = 11'd1500;
  localparam logic [10:0] CountMax   = 11'd2047;
  localparam logic [10:0] MinCount   = 11'd20;

  // Fixed-point constants
  localparam logic [47:0] CostMax   = 48'hFFFF_FFFF_FFFF;
  localparam logic [47:0] BestReset = 48'd65536000000;
  localparam logic [47:0] BigCost   = 48'd65536000000000;
  localparam logic signed [25:0] TolQ16 = 26'sd655;
  localparam logic signed [15:0] BigErr = 16'sd640;
  localparam logic signed [23:0] StepMax = 24'sd8388607;
  localparam logic signed [23:0] StepP   = 24'sd32768;
  localparam logic signed [23:0] StepI   = 24'sd6554;
  localparam logic signed [23:0] StepD   = 24'sd32768;
  localparam logic [3:0]  ScaleUp   = 4'd11;
  localparam logic [3:0]  ScaleDown = 4'd9;
  // ceil(2^26 / 10); the product shifted by 26 is exact below 2^26 / 6
  localparam logic signed [23:0] RecipTen = 24'sd6710887;

  // Twiddle phases
  localparam logic [1:0] PhTry  = 2'd0;
  localparam logic [1:0] PhUp   = 2'd1;
  localparam logic [1:0] PhDown = 2'd2;

  typedef enum logic [3:0] {
    StIdle, StSqe, StAcc, StDiv, StTwid, StSmul, StSwr,
    StM0, StM1, StM2, StM3, StDrv, StSqd, StOut
  } ptt_state_e;

  typedef enum logic [2:0] {
    MulNone, MulErr, MulProp, MulDiff, MulInteg, MulDrive, MulStep
  } ptt_mul_sel_e;

  // Per-cycle controls decoded from the sequencer state
  typedef struct packed {
    ptt_mul_sel_e mul_sel;
    logic         div_start;
  } ptt_ctl_t;

endpackage

// ===== hw/rtl/ptt_mul.sv =====
// Shared signed multiplier with registered product.
module ptt_mul import ptt_pkg::*; (
  input  logic               clk_i,
  input  logic signed [31:0] a_i,
  input  logic signed [23:0] b_i,
  output logic signed [55:0] p_o
);

  logic signed [55:0] p_q, p_d;

  assign p_d = 56'(a_i) * 56'(b_i);

  always_ff @(posedge clk_i) begin
    p_q <= p_d;
  end

  assign p_o = p_q;

endmodule

// ===== hw/rtl/ptt_div.sv =====
// Iterative restoring divider: 48-bit dividend by 11-bit divisor, one bit a cycle.
module ptt_div import ptt_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [47:0] dividend_i,
  input  logic [10:0] divisor_i,
  output logic        done_o,
  output logic [47:0] quot_o
);

  logic [47:0] quo_q, quo_d;
  logic [10:0] rem_q, rem_d;
  logic [10:0] dvs_q, dvs_d;
  logic [5:0]  cnt_q, cnt_d;
  logic        busy_q, busy_d;
  logic        done_q, done_d;
  logic [11:0] trial;

  // One quotient bit per cycle
  always_comb begin
    quo_d  = quo_q;
    rem_d  = rem_q;
    dvs_d  = dvs_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    trial  = {rem_q, quo_q[47]};
    if (start_i && !busy_q) begin
      quo_d  = dividend_i;
      rem_d  = '0;
      dvs_d  = divisor_i;
      cnt_d  = '0;
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (trial >= {1'b0, dvs_q}) begin
        rem_d = 11'(trial - {1'b0, dvs_q});
        quo_d = {quo_q[46:0], 1'b1};
      end else begin
        rem_d = trial[10:0];
        quo_d = {quo_q[46:0], 1'b0};
      end
      cnt_d = cnt_q + 6'd1;
      if (cnt_q == 6'd47) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    dvs_q <= dvs_d;
  end

  assign done_o = done_q;
  assign quot_o = quo_q;

endmodule

// ===== hw/rtl/pid_with_twiddle_tuning_core.sv =====
// Top level: PID controller with online twiddle gain tuning.
//
// Usage:
//   Input channel (in_valid_i/in_ready_o) carries one Q7.8 error sample per
//   request. Output channel (out_valid_o/out_ready_i) returns one result per
//   sample: saturated Q7.8 drive, a retuned flag and the coefficient index
//   now under tuning. Gains and the tuning enable are written through the
//   cfg_we_i/cfg_idx_i/cfg_data_i port while the block is idle; writing any
//   gain reloads all gains and restarts the tuner.
//   From accept to result a sample passes StSqe, StAcc, StM0 to StM3, StDrv,
//   StSqd and StOut; a tuning trigger adds StDiv and StTwid, and a step rescale
//   adds StSmul and StSwr. All products go through one shared 32x24 multiplier
//   (the step rescale uses a reciprocal of ten); the cost normalization runs
//   on a bit-serial 48-bit divider, which sets the worst case.
//   in_ready_o is high only while the sequencer is idle, so a new sample is
//   taken only after the last one has left StOut. The result sits in an
//   output register, so the next sample is taken while it still waits;
//   a stalled receiver holds the block only when a second result is ready.
//   Reset clears all terms, cost and tuner state, sets gains to zero, steps
//   to 0.5/0.1/0.5 and disables tuning.
module pid_with_twiddle_tuning_core import ptt_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic signed [15:0] error_sample_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic signed [15:0] drive_value_o,
  output logic               retuned_o,
  output logic [1:0]         tuned_coefficient_o,
  input  logic               cfg_we_i,
  input  logic [1:0]         cfg_idx_i,
  input  logic [23:0]        cfg_data_i
);

  ptt_state_e state_q, state_d;
  ptt_ctl_t   ctl;

  logic signed [15:0] prop_q, prop_d, e_q, e_d, dv_q, dv_d;
  logic signed [16:0] diff_q, diff_d;
  logic signed [31:0] integ_q, integ_d;
  logic [47:0] cost_q, cost_d, best_q, best_d;
  logic [10:0] sc_q, sc_d;
  logic [1:0]  coord_q, coord_d, phase_q, phase_d, tk_q, tk_d;
  logic        restart_q, restart_d, tune_q, tune_d, retuned_q, retuned_d;
  logic [3:0]  num_q, num_d;
  logic signed [23:0] gain_q [3];
  logic signed [23:0] gain_d [3];
  logic signed [23:0] step_q [3];
  logic signed [23:0] step_d [3];
  logic signed [23:0] rgain_q [3];
  logic signed [23:0] rgain_d [3];
  logic signed [57:0] acc_q, acc_d;
  logic        out_valid_q, out_valid_d, oret_q, oret_d;
  logic signed [15:0] odrv_q, odrv_d;
  logic [1:0]  ocoef_q, ocoef_d;

  logic signed [31:0] mul_a;
  logic signed [23:0] mul_b;
  logic signed [55:0] prod;
  logic        div_done;
  logic [47:0] quot;
  logic [47:0] div_dividend;
  logic [10:0] div_divisor;

  // Combinational helpers
  logic        in_acc, trig, big, tw_run, tw_scale, out_free;
  logic [48:0] cost_sum;
  logic [47:0] cost_new;
  logic [10:0] sc_new;
  logic signed [32:0] integ_sum;
  logic [1:0]  k, ph;
  logic signed [25:0] g_ext, s_ext, g_plus, g_minus2, step_sum;
  logic signed [57:0] neg;
  logic signed [41:0] dv_full;
  logic [23:0] rq;
  logic [24:0] step_up;
  logic [23:0] step_dn;

  assign in_acc   = in_valid_i && in_ready_o;
  assign out_free = !out_valid_q || out_ready_i;

  function automatic logic signed [23:0] sat24(input logic signed [25:0] x);
    if (x > 26'sd8388607)       return 24'sh7FFFFF;
    else if (x < -26'sd8388608) return 24'sh800000;
    else                        return x[23:0];
  endfunction

  // Cost after adding the square of the sample, count after increment
  assign cost_sum = {1'b0, cost_q} + {1'b0, prod[47:0]};
  assign cost_new = cost_sum[48] ? CostMax : cost_sum[47:0];
  assign sc_new   = (sc_q < CountMax) ? sc_q + 11'd1 : sc_q;
  assign big      = (e_q > BigErr) || (e_q < -BigErr);
  assign trig     = tune_q && ((sc_new == HorizonMax) || ((sc_new > MinCount) && big));

  // Twiddle operands
  assign k        = (coord_q == 2'd3) ? 2'd0 : coord_q;
  assign ph       = (phase_q == 2'd3) ? PhTry : phase_q;
  assign g_ext    = 26'(gain_q[k]);
  assign s_ext    = 26'(step_q[k]);
  assign g_plus   = g_ext + s_ext;
  assign g_minus2 = g_ext - (s_ext <<< 1);
  assign step_sum = 26'(step_q[0]) + 26'(step_q[1]) + 26'(step_q[2]);
  assign tw_run   = step_sum > TolQ16;
  assign tw_scale = tw_run && (ph != PhTry) && ((quot < best_q) || (ph == PhDown));

  // Step rescale: up is s + (s+5)/10, down is s - (s+4)/10
  assign rq      = prod[49:26];
  assign step_up = 25'(step_q[tk_q]) + 25'(rq);
  assign step_dn = step_q[tk_q] - rq;

  // Drive: negate, round half up to Q.8, saturate
  assign neg     = 58'sd32768 - acc_q;
  assign dv_full = neg[57:16];

  // Sequencer next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      StIdle: if (in_valid_i) state_d = StSqe;
      StSqe:  state_d = StAcc;
      StAcc:  state_d = trig ? StDiv : StM0;
      StDiv:  if (div_done) state_d = StTwid;
      StTwid: state_d = tw_scale ? StSmul : StM0;
      StSmul: state_d = StSwr;
      StSwr:  state_d = StM0;
      StM0:   state_d = StM1;
      StM1:   state_d = StM2;
      StM2:   state_d = StM3;
      StM3:   state_d = StDrv;
      StDrv:  state_d = StSqd;
      StSqd:  state_d = StOut;
      StOut:  if (out_free) state_d = StIdle;
      default: state_d = StIdle;
    endcase
  end

  // Per-state controls
  always_comb begin
    ctl = '{mul_sel: MulNone, div_start: 1'b0};
    case (state_q)
      StSqe:  ctl.mul_sel = MulErr;
      StAcc:  ctl.div_start = trig;
      StSmul: ctl.mul_sel = MulStep;
      StM0:   ctl.mul_sel = MulProp;
      StM1:   ctl.mul_sel = MulDiff;
      StM2:   ctl.mul_sel = MulInteg;
      StSqd:  ctl.mul_sel = MulDrive;
      // keep the squared drive on the product while the result waits
      StOut:  ctl.mul_sel = MulDrive;
      default: ctl.mul_sel = MulNone;
    endcase
  end

  assign in_ready_o = (state_q == StIdle);

  // Multiplier operand select
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (ctl.mul_sel)
      MulErr:   begin mul_a = 32'(e_q);     mul_b = 24'(e_q);      end
      MulProp:  begin mul_a = 32'(prop_q);  mul_b = gain_q[0];     end
      MulDiff:  begin mul_a = 32'(diff_q);  mul_b = gain_q[2];     end
      MulInteg: begin mul_a = integ_q;      mul_b = gain_q[1];     end
      MulDrive: begin mul_a = 32'(dv_q);    mul_b = 24'(dv_q);     end
      MulStep:  begin
        mul_a = 32'(step_q[tk_q]) + ((num_q == ScaleDown) ? 32'sd4 : 32'sd5);
        mul_b = RecipTen;
      end
      default:  begin mul_a = '0;           mul_b = '0;            end
    endcase
  end

  // Divider operands: cost over count
  assign div_dividend = big ? BigCost : cost_new;
  assign div_divisor  = sc_new;

  ptt_mul u_mul (
    .clk_i (clk_i),
    .a_i   (mul_a),
    .b_i   (mul_b),
    .p_o   (prod)
  );

  ptt_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (ctl.div_start),
    .dividend_i (div_dividend),
    .divisor_i  (div_divisor),
    .done_o     (div_done),
    .quot_o     (quot)
  );

  // Datapath and tuner state
  always_comb begin
    prop_d = prop_q;  diff_d = diff_q;  integ_d = integ_q;  e_d = e_q;
    cost_d = cost_q;  best_d = best_q;  sc_d = sc_q;
    coord_d = coord_q; phase_d = phase_q; restart_d = restart_q;
    tune_d = tune_q;  retuned_d = retuned_q; tk_d = tk_q; num_d = num_q;
    acc_d = acc_q;    dv_d = dv_q;
    gain_d = gain_q;  step_d = step_q;  rgain_d = rgain_q;
    out_valid_d = out_valid_q; odrv_d = odrv_q; oret_d = oret_q; ocoef_d = ocoef_q;
    integ_sum = 33'(integ_q) + 33'(error_sample_i);

    if (out_valid_q && out_ready_i) out_valid_d = 1'b0;

    case (state_q)
      StIdle: if (in_acc) begin
        e_d       = error_sample_i;
        retuned_d = 1'b0;
        if (restart_q) begin
          prop_d = '0; diff_d = '0; integ_d = '0;
          restart_d = 1'b0;
        end else begin
          prop_d = error_sample_i;
          diff_d = 17'(error_sample_i) - 17'(prop_q);
          if (integ_sum > 33'sh0_7FFF_FFFF)       integ_d = 32'sh7FFF_FFFF;
          else if (integ_sum < -33'sh0_8000_0000) integ_d = 32'sh8000_0000;
          else                                    integ_d = integ_sum[31:0];
        end
      end
      StAcc: begin
        if (trig) begin
          cost_d = '0;
          sc_d   = 11'd1;
        end else begin
          cost_d = cost_new;
          sc_d   = sc_new;
        end
      end
      StTwid: begin
        if (!tw_run) begin
          restart_d = 1'b0;
        end else begin
          restart_d = 1'b1;
          retuned_d = 1'b1;
          tk_d      = k;
          case (ph)
            PhUp: begin
              if (quot < best_q) begin
                best_d  = quot;
                num_d   = ScaleUp;
                phase_d = PhTry;
                coord_d = (k == 2'd2) ? 2'd0 : k + 2'd1;
              end else begin
                gain_d[k] = sat24(g_minus2);
                phase_d   = PhDown;
                coord_d   = k;
              end
            end
            PhDown: begin
              if (quot < best_q) begin
                best_d = quot;
                num_d  = ScaleUp;
              end else begin
                gain_d[k] = sat24(g_plus);
                num_d     = ScaleDown;
              end
              phase_d = PhTry;
              coord_d = (k == 2'd2) ? 2'd0 : k + 2'd1;
            end
            default: begin
              gain_d[k] = sat24(g_plus);
              best_d    = quot;
              phase_d   = PhUp;
              coord_d   = k;
            end
          endcase
        end
      end
      StSwr: begin
        if (num_q == ScaleDown)          step_d[tk_q] = $signed(step_dn);
        else if (step_up > 25'(StepMax)) step_d[tk_q] = StepMax;
        else                             step_d[tk_q] = $signed(step_up[23:0]);
      end
      StM1:  acc_d = 58'(prod);
      StM2:  acc_d = acc_q + 58'(prod);
      StM3:  acc_d = acc_q + 58'(prod);
      StDrv: begin
        if (dv_full > 42'sd32767)       dv_d = 16'sh7FFF;
        else if (dv_full < -42'sd32768) dv_d = 16'sh8000;
        else                            dv_d = dv_full[15:0];
      end
      StOut: if (out_free) begin
        if (!restart_q) cost_d = cost_sum[48] ? CostMax : cost_sum[47:0];
        out_valid_d = 1'b1;
        odrv_d  = dv_q;
        oret_d  = retuned_q;
        ocoef_d = coord_q;
      end
      default: ;
    endcase

    // Register writes: a gain write reloads the whole tuner
    if (cfg_we_i) begin
      if (cfg_idx_i == RegTune) begin
        tune_d = cfg_data_i[0];
      end else begin
        rgain_d[cfg_idx_i] = cfg_data_i;
        prop_d = '0; diff_d = '0; integ_d = '0;
        cost_d = '0; best_d = BestReset; sc_d = 11'd1;
        coord_d = '0; phase_d = PhTry; restart_d = 1'b0;
        gain_d  = rgain_d;
        step_d[0] = StepP; step_d[1] = StepI; step_d[2] = StepD;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      prop_q <= '0; diff_q <= '0; integ_q <= '0;
      cost_q <= '0; best_q <= BestReset; sc_q <= 11'd1;
      coord_q <= '0; phase_q <= PhTry; restart_q <= 1'b0;
      tune_q <= 1'b0; retuned_q <= 1'b0;
      gain_q[0] <= '0; gain_q[1] <= '0; gain_q[2] <= '0;
      rgain_q[0] <= '0; rgain_q[1] <= '0; rgain_q[2] <= '0;
      step_q[0] <= StepP; step_q[1] <= StepI; step_q[2] <= StepD;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      prop_q <= prop_d; diff_q <= diff_d; integ_q <= integ_d;
      cost_q <= cost_d; best_q <= best_d; sc_q <= sc_d;
      coord_q <= coord_d; phase_q <= phase_d; restart_q <= restart_d;
      tune_q <= tune_d; retuned_q <= retuned_d;
      gain_q <= gain_d; rgain_q <= rgain_d; step_q <= step_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    e_q <= e_d; tk_q <= tk_d; num_q <= num_d;
    acc_q <= acc_d; dv_q <= dv_d;
    odrv_q <= odrv_d; oret_q <= oret_d; ocoef_q <= ocoef_d;
  end

  assign out_valid_o         = out_valid_q;
  assign drive_value_o       = odrv_q;
  assign retuned_o           = oret_q;
  assign tuned_coefficient_o = ocoef_q;

endmodule

// ===== hw/rtl/ptt_checker.sv =====
// Port-level checks for the PID twiddle core, bound to the top level.
module ptt_checker import ptt_pkg::*; (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_valid_i,
  input logic               in_ready_o,
  input logic               out_valid_o,
  input logic               out_ready_i,
  input logic signed [15:0] drive_value_o,
  input logic               retuned_o,
  input logic [1:0]         tuned_coefficient_o
);

  // A request keeps the sequencer busy for the next cycle
  a_busy_after_req: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("input taken twice in a row");

  // Coefficient index stays in range
  a_coef_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> tuned_coefficient_o != 2'd3)
    else $error("coefficient index out of range");

  // A stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(drive_value_o)
      && $stable(retuned_o) && $stable(tuned_coefficient_o))
    else $error("stalled result changed");

endmodule

bind pid_with_twiddle_tuning_core ptt_checker u_ptt_checker (
  .clk_i               (clk_i),
  .rst_ni              (rst_ni),
  .in_valid_i          (in_valid_i),
  .in_ready_o          (in_ready_o),
  .out_valid_o         (out_valid_o),
  .out_ready_i         (out_ready_i),
  .drive_value_o       (drive_value_o),
  .retuned_o           (retuned_o),
  .tuned_coefficient_o (tuned_coefficient_o)
);

// ===== verif/pid_with_twiddle_tuning_core_tb.sv =====
// Self-checking testbench for the PID controller with twiddle gain tuning.
`timescale 1ns / 100ps

module pid_with_twiddle_tuning_core_tb;
  import ptt_pkg::*;

  localparam int StallLimit = 3000;
  localparam int HoldCycles = 400;
  localparam int DrainCycles = 150;

  typedef struct {
    logic signed [15:0] drive;
    logic               retuned;
    logic [1:0]         coef;
  } drive_result_t;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               in_valid_i = 1'b0;
  logic               in_ready_o;
  logic signed [15:0] error_sample_i = '0;
  logic               out_valid_o;
  logic               out_ready_i = 1'b0;
  logic signed [15:0] drive_value_o;
  logic               retuned_o;
  logic [1:0]         tuned_coefficient_o;
  logic               cfg_we_i = 1'b0;
  logic [1:0]         cfg_idx_i = '0;
  logic [23:0]        cfg_data_i = '0;

  drive_result_t expected_drives[$];
  int  n_errors = 0;
  bit  idle_on = 1'b1;
  int  hold_left = 0;
  int  stall_cnt = 0;

  // Predictor state
  longint reg_gain[3];
  bit     reg_tune;
  longint p_term, d_term, i_term;
  longint unsigned cost_acc, best_cost;
  int     samp_cnt, coord, phase;
  bit     restart;
  longint gain[3], step[3];

  pid_with_twiddle_tuning_core uut (.*);

  // Clock: 4 ns period
  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  function automatic longint sat24(longint x);
    if (x > 8388607) return 8388607;
    if (x < -8388608) return -8388608;
    return x;
  endfunction

  function automatic longint unsigned cost_add(longint unsigned a, longint unsigned b);
    longint unsigned s;
    s = a + b;
    return (s > CostMax) ? longint'(CostMax) : s;
  endfunction

  function automatic longint rescale(longint st, longint num);
    longint v;
    v = (st * num + 5) / 10;
    if (v > StepMax) v = StepMax;
    if (v < 0) v = 0;
    return v;
  endfunction

  task automatic reinit_tuner();
    p_term = 0; d_term = 0; i_term = 0;
    cost_acc = 0; best_cost = BestReset;
    samp_cnt = 1; coord = 0; phase = PhTry; restart = 0;
    for (int k = 0; k < 3; k++) gain[k] = reg_gain[k];
    step[0] = StepP; step[1] = StepI; step[2] = StepD;
  endtask

  // One coordinate-descent step on the gain under tuning
  task automatic twiddle_step(longint unsigned cost);
    int k;
    k = coord;
    if (phase == PhTry) begin
      gain[k] = sat24(gain[k] + step[k]);
      best_cost = cost;
      phase = PhUp;
    end else if (phase == PhUp) begin
      if (cost < best_cost) begin
        best_cost = cost;
        step[k] = rescale(step[k], ScaleUp);
        phase = PhTry;
        coord = (k + 1) % 3;
      end else begin
        gain[k] = sat24(gain[k] - 2 * step[k]);
        phase = PhDown;
      end
    end else begin
      if (cost < best_cost) begin
        best_cost = cost;
        step[k] = rescale(step[k], ScaleUp);
      end else begin
        gain[k] = sat24(gain[k] + step[k]);
        step[k] = rescale(step[k], ScaleDown);
      end
      phase = PhTry;
      coord = (k + 1) % 3;
    end
  endtask

  // Expected drive for one accepted error sample
  task automatic predict_drive(logic signed [15:0] es);
    longint e, it, acc, dv;
    longint unsigned cost;
    bit big;
    drive_result_t r;
    e = es;
    r.retuned = 1'b0;
    d_term = e - p_term;
    p_term = e;
    it = i_term + e;
    if (it > 64'sd2147483647) it = 64'sd2147483647;
    if (it < -64'sd2147483648) it = -64'sd2147483648;
    i_term = it;
    if (restart) begin
      d_term = 0; p_term = 0; i_term = 0; restart = 0;
    end
    cost_acc = cost_add(cost_acc, longint'(e * e));
    if (samp_cnt < CountMax) samp_cnt++;
    big = (e > BigErr) || (e < -BigErr);
    if (reg_tune && (samp_cnt == HorizonMax || (samp_cnt > MinCount && big))) begin
      cost = big ? longint'(BigCost) : cost_acc;
      cost = cost / longint'(samp_cnt);
      if (step[0] + step[1] + step[2] > TolQ16) begin
        twiddle_step(cost);
        restart = 1;
        r.retuned = 1'b1;
      end else begin
        restart = 0;
      end
      samp_cnt = 1;
      cost_acc = 0;
    end
    acc = p_term * gain[0] + d_term * gain[2] + i_term * gain[1];
    dv = (-acc + 32768) >>> 16;
    if (dv > 32767) dv = 32767;
    if (dv < -32768) dv = -32768;
    if (!restart) cost_acc = cost_add(cost_acc, longint'(dv * dv));
    r.drive = dv[15:0];
    r.coef = coord[1:0];
    expected_drives.push_back(r);
  endtask

  // Wait until every result is back and the sequencer has settled
  task automatic drain();
    while (expected_drives.size() != 0) @(negedge clk_i);
    repeat (DrainCycles) @(negedge clk_i);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [23:0] data);
    @(negedge clk_i);
    cfg_we_i = 1'b1;
    cfg_idx_i = idx;
    cfg_data_i = data;
    @(negedge clk_i);
    cfg_we_i = 1'b0;
    if (idx == RegTune) begin
      reg_tune = data[0];
    end else begin
      reg_gain[idx] = longint'(signed'(data));
      reinit_tuner();
    end
  endtask

  task automatic set_gains(logic [23:0] kp, logic [23:0] ki, logic [23:0] kd);
    write_reg(RegKp, kp);
    write_reg(RegKi, ki);
    write_reg(RegKd, kd);
  endtask

  // Send one error sample; returns after the request is accepted
  task automatic send_sample(logic signed [15:0] es);
    if (idle_on && $urandom_range(0, 5) == 0) begin
      in_valid_i = 1'b0;
      repeat ($urandom_range(1, 13)) @(negedge clk_i);
    end
    in_valid_i = 1'b1;
    error_sample_i = es;
    do @(posedge clk_i); while (!in_ready_o);
    predict_drive(es);
    @(negedge clk_i);
    in_valid_i = 1'b0;
  endtask

  function automatic logic signed [15:0] small_err();
    return $signed(16'($urandom_range(0, 1280))) - 16'sd640;
  endfunction

  function automatic logic signed [15:0] big_err();
    logic signed [15:0] m;
    m = 16'($urandom_range(641, 32767));
    return $urandom_range(0, 1) ? m : -m;
  endfunction

  function automatic logic [23:0] mid_gain();
    return 24'($signed($urandom_range(0, 262144)) - 131072);
  endfunction

  // Extremes of gains and samples, then a forced retune that saturates a gain
  task automatic test_directed();
    set_gains(24'h7FFFFF, 24'h800000, 24'h7FFFFF);
    write_reg(RegTune, 1'b0);
    send_sample(-16'sd32768);
    send_sample(16'sd32767);
    send_sample(16'sd0);
    send_sample(-16'sd1);
    send_sample(16'sd1);
    drain();
    write_reg(RegTune, 1'b1);
    for (int n = 0; n < 20; n++) send_sample(n[0] ? 16'sd640 : -16'sd640);
    send_sample(16'sd641);
    send_sample(-16'sd641);
    send_sample(16'sd32767);
  endtask

  // Horizons ended by a large error, random gains and content
  task automatic test_twiddle_sequences();
    for (int s = 0; s < 10; s++) begin
      if (s % 3 == 0) begin
        drain();
        set_gains(mid_gain(), mid_gain(), mid_gain());
        write_reg(RegTune, 1'b1);
      end
      repeat ($urandom_range(20, 28)) begin
        if ($urandom_range(0, 9) == 0) send_sample(16'($urandom));
        else send_sample(small_err());
      end
      send_sample(big_err());
    end
  endtask

  // Full horizon without large errors
  task automatic test_horizon();
    drain();
    set_gains(mid_gain(), mid_gain(), mid_gain());
    write_reg(RegTune, 1'b1);
    repeat (1499) send_sample(small_err());
    repeat (3) send_sample(small_err());
  endtask

  task automatic test_tune_off();
    drain();
    write_reg(RegTune, 1'b0);
    set_gains(24'($urandom), 24'($urandom), 24'($urandom));
    repeat (100) send_sample(16'($urandom));
  endtask

  // Receiver holds off long while requests keep coming
  task automatic test_backpressure();
    hold_left = HoldCycles;
    repeat (8) send_sample(16'($urandom));
  endtask

  task automatic test_no_idle();
    drain();
    idle_on = 1'b0;
    set_gains(24'h800000, 24'h000000, 24'h800000);
    write_reg(RegTune, 1'b1);
    repeat (60) send_sample($urandom_range(0, 3) == 0 ? big_err() : small_err());
  endtask

  // Receiver ready with random stall bursts and the long hold
  initial begin : receiver
    int burst;
    burst = 0;
    forever begin
      @(negedge clk_i);
      if (hold_left > 0) begin
        hold_left--;
        out_ready_i = 1'b0;
      end else if (burst > 0) begin
        burst--;
        out_ready_i = 1'b0;
      end else if (idle_on && $urandom_range(0, 5) == 0) begin
        burst = $urandom_range(1, 13) - 1;
        out_ready_i = 1'b0;
      end else begin
        out_ready_i = 1'b1;
      end
    end
  end

  // Result checker
  always @(posedge clk_i) begin
    drive_result_t x;
    if (out_valid_o && out_ready_i) begin
      if (expected_drives.size() == 0) begin
        $display("%0t: unexpected result drive=%0d", $time, drive_value_o);
        n_errors++;
      end else begin
        x = expected_drives.pop_front();
        if (drive_value_o !== x.drive) begin
          $display("%0t: drive exp %0d got %0d", $time, x.drive, drive_value_o);
          n_errors++;
        end
        if (retuned_o !== x.retuned) begin
          $display("%0t: retuned exp %0d got %0d", $time, x.retuned, retuned_o);
          n_errors++;
        end
        if (tuned_coefficient_o !== x.coef) begin
          $display("%0t: coef exp %0d got %0d", $time, x.coef, tuned_coefficient_o);
          n_errors++;
        end
      end
    end
  end

  // Watchdog on cycles without any accepted request or result
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) stall_cnt <= 0;
    else stall_cnt <= stall_cnt + 1;
    if (stall_cnt >= StallLimit) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  initial begin
    reg_gain = '{0, 0, 0};
    reg_tune = 0;
    reinit_tuner();
    repeat (9) @(negedge clk_i);
    rst_ni = 1'b1;
    test_directed();
    test_twiddle_sequences();
    test_horizon();
    test_tune_off();
    test_backpressure();
    test_no_idle();
    drain();
    if (n_errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
